// ===== sv/stb_pkg.sv =====
// Shared constants, types and helper functions of the scaled tinted sprite blitter.
`default_nettype none

package stb_pkg;

	localparam int MAX_SIDE        = 64;
	localparam int STORE_DEPTH     = 4096;
	localparam int SCALE_FRAC_BITS = 8;

	localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
	localparam int POS_W       = $clog2(MAX_SIDE);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = POS_W + SIDE_W + 1;
	localparam int SCALE_W     = 16;
	localparam int COORD_W     = 16;
	localparam int CHAN_W      = 8;
	localparam int TINT_W      = 9;
	localparam int TINT_FRAC   = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int CFG_W       = 27;
	localparam int CFG_SIDE_W  = 7;
	localparam int REG_IDX_W   = 3;
	localparam int CMD_W       = 2;
	localparam int LOAD_ADDR_W = 12;
	localparam int SRC_W       = 6;
	localparam int POS_PROD_W  = POS_W + SCALE_W;
	localparam int SIDE_PROD_W = SIDE_W + SCALE_W;
	localparam int SAMP_W      = POS_PROD_W - SCALE_FRAC_BITS;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
	localparam logic [TINT_W-1:0]  TINT_ONE  = TINT_W'(1) << TINT_FRAC;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SPRITE_WIDTH  = 3'd0,
		REG_SPRITE_HEIGHT = 3'd1,
		REG_DEST_X        = 3'd2,
		REG_DEST_Y        = 3'd3,
		REG_SCALE         = 3'd4,
		REG_INV_SCALE     = 3'd5,
		REG_TINT          = 3'd6
	} reg_t;

	typedef enum logic [1:0] {
		MODE_UNITY = 2'd0,
		MODE_DOWN  = 2'd1,
		MODE_UP    = 2'd2
	} mode_t;

	// One walk position leaving the walk sequencer, products already registered.
	typedef struct packed {
		logic                   valid;
		mode_t                  mode;
		logic [POS_W-1:0]       col;
		logic [POS_W-1:0]       row;
		logic [POS_PROD_W-1:0]  col_inv;
		logic [POS_PROD_W-1:0]  row_inv;
		logic [POS_PROD_W-1:0]  col_scl;
		logic [POS_PROD_W-1:0]  row_scl;
		logic [SIDE_PROD_W-1:0] col_scl_next;
		logic [SIDE_PROD_W-1:0] row_scl_next;
		logic                   drawn;
		logic                   last;
	} step_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

	// Scale one channel by a 1.8 tint, saturate at full scale.
	function automatic logic [CHAN_W-1:0] tint_chan(input logic [CHAN_W-1:0] b,
		input logic [TINT_W-1:0] t);
		logic [CHAN_W+TINT_W-1:0] p;
		logic [CHAN_W-1:0]        r;
		p = {{TINT_W{1'b0}}, b} * {{CHAN_W{1'b0}}, t};
		if (p[CHAN_W+TINT_W-1:TINT_FRAC+CHAN_W] != '0) begin
			r = '1;
		end else begin
			r = p[TINT_FRAC+CHAN_W-1:TINT_FRAC];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stb_ifs.sv =====
// Request and fill channel interfaces of the scaled tinted sprite blitter.
`default_nettype none

interface stb_req_if import stb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       cmd;
	logic [LOAD_ADDR_W-1:0] load_addr;
	logic [CHAN_W-1:0]      red_in;
	logic [CHAN_W-1:0]      green_in;
	logic [CHAN_W-1:0]      blue_in;
	logic                   visible;

	modport source (output valid, cmd, load_addr, red_in, green_in, blue_in, visible,
		input ready);
	modport sink (input valid, cmd, load_addr, red_in, green_in, blue_in, visible,
		output ready);
endinterface

interface stb_fill_if import stb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] left;
	logic signed [COORD_W-1:0] top;
	logic signed [COORD_W-1:0] right;
	logic signed [COORD_W-1:0] bottom;
	logic [CHAN_W-1:0]         red_out;
	logic [CHAN_W-1:0]         green_out;
	logic [CHAN_W-1:0]         blue_out;
	logic [SRC_W-1:0]          src_col;
	logic [SRC_W-1:0]          src_row;
	logic                      drawn;
	logic                      last;

	modport source (output valid, left, top, right, bottom, red_out, green_out, blue_out,
		src_col, src_row, drawn, last, input ready);
	modport sink (input valid, left, top, right, bottom, red_out, green_out, blue_out,
		src_col, src_row, drawn, last, output ready);
endinterface

`default_nettype wire

// ===== sv/stb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/stb_walk.sv =====
// Walk sequencer: start and step commands, walk counters and position products.
`default_nettype none

module stb_walk import stb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [CMD_W-1:0]   cmd,
	input  logic               visible,
	input  logic [SIDE_W-1:0]  side_w,
	input  logic [SIDE_W-1:0]  side_h,
	input  logic [SCALE_W-1:0] scale,
	input  logic [SCALE_W-1:0] inv_scale,
	output step_t              step_s1
);

	logic [POS_W-1:0]       walk_col_q, walk_row_q;
	logic [SIDE_W-1:0]      walk_rows_q;
	logic                   walk_active_q;
	logic                   valid_s1;
	logic [SIDE_PROD_W-1:0] span_w, span_h;
	logic [SIDE_W-1:0]      start_cols, start_rows;
	logic [SIDE_W-1:0]      col_next, row_next;
	logic                   is_start, is_step, is_last;
	mode_t                  mode;

	mode_t                  mode_s1;
	logic [POS_W-1:0]       col_s1, row_s1;
	logic [POS_PROD_W-1:0]  col_inv_s1, row_inv_s1, col_scl_s1, row_scl_s1;
	logic [SIDE_PROD_W-1:0] col_scl_next_s1, row_scl_next_s1;
	logic                   drawn_s1, last_s1;

	assign is_start = accept && (cmd == CMD_START);
	assign is_step  = accept && (cmd == CMD_STEP) && walk_active_q;
	assign is_last  = (walk_col_q == '0) && (walk_row_q == '0);

	// Downscale shrinks the walk to floor(side * scale).
	assign span_w = side_w * scale;
	assign span_h = side_h * scale;

	always_comb begin
		if (scale < SCALE_ONE) begin
			start_cols = SIDE_W'(span_w >> SCALE_FRAC_BITS);
			start_rows = SIDE_W'(span_h >> SCALE_FRAC_BITS);
		end else begin
			start_cols = side_w;
			start_rows = side_h;
		end
	end

	always_comb begin
		if (scale == SCALE_ONE) begin
			mode = MODE_UNITY;
		end else if (scale < SCALE_ONE) begin
			mode = MODE_DOWN;
		end else begin
			mode = MODE_UP;
		end
	end

	assign col_next = SIDE_W'(walk_col_q) + 1'b1;
	assign row_next = SIDE_W'(walk_row_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_col_q    <= '0;
			walk_row_q    <= '0;
			walk_rows_q   <= '0;
			walk_active_q <= 1'b0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= is_step;
			if (is_start) begin
				walk_rows_q   <= start_rows;
				walk_col_q    <= POS_W'(start_cols - 1'b1);
				walk_row_q    <= POS_W'(start_rows - 1'b1);
				walk_active_q <= (start_cols != '0) && (start_rows != '0);
			end else if (is_step) begin
				if (is_last) begin
					walk_active_q <= 1'b0;
				end else if (walk_row_q != '0) begin
					walk_row_q <= walk_row_q - 1'b1;
				end else begin
					walk_row_q <= POS_W'(walk_rows_q - 1'b1);
					walk_col_q <= walk_col_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			mode_s1         <= mode;
			col_s1          <= walk_col_q;
			row_s1          <= walk_row_q;
			col_inv_s1      <= walk_col_q * inv_scale;
			row_inv_s1      <= walk_row_q * inv_scale;
			col_scl_s1      <= walk_col_q * scale;
			row_scl_s1      <= walk_row_q * scale;
			col_scl_next_s1 <= col_next * scale;
			row_scl_next_s1 <= row_next * scale;
			drawn_s1        <= visible;
			last_s1         <= is_last;
		end
	end

	assign step_s1 = '{
		valid:        valid_s1,
		mode:         mode_s1,
		col:          col_s1,
		row:          row_s1,
		col_inv:      col_inv_s1,
		row_inv:      row_inv_s1,
		col_scl:      col_scl_s1,
		row_scl:      row_scl_s1,
		col_scl_next: col_scl_next_s1,
		row_scl_next: row_scl_next_s1,
		drawn:        drawn_s1,
		last:         last_s1
	};

endmodule

`default_nettype wire

// ===== sv/scaled_tinted_sprite_blit.sv =====
// Top level of the scaled tinted sprite blitter: registers, sprite memory, fill output.
//
//   channel     dir  handshake       carries
//   pixel_req   in   valid / ready   cmd, load_addr, red_in, green_in, blue_in, visible
//   rect_out    out  valid / ready   left, top, right, bottom, tinted rgb, src, drawn, last
//   write_en    in   none            reg_index, write_data (one register per cycle)
//
// A step request passes through the products register, then the sprite memory read,
// then the tint into the output register, which it enters once that is free.
// At most one step sits in the products or memory stage; ready drops until it reaches
// the output register, which frees the front end while the fill waits to be taken.
// Reset clears walk state and loads the register defaults; sprite memory is not cleared.
`default_nettype none

module scaled_tinted_sprite_blit import stb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	stb_req_if.sink              pixel_req,
	stb_fill_if.source           rect_out,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] reg_index,
	input  logic [CFG_W-1:0]     write_data
);

	// configuration registers
	logic [CFG_SIDE_W-1:0] sprite_width_q, sprite_height_q;
	logic [COORD_W-1:0]    dest_x_q, dest_y_q;
	logic [SCALE_W-1:0]    scale_q, inv_scale_q;
	logic [CFG_W-1:0]      tint_q;

	logic [SIDE_W-1:0]     side_w, side_h;
	logic                  req_accept;
	logic                  store_we;
	step_t                 step_s1;

	// position stage
	logic [SAMP_W-1:0]     col_raw, row_raw;
	logic [SIDE_W-1:0]     col_lim, row_lim;
	logic [POS_W-1:0]      sc, sr;
	logic [IDX_W-1:0]      idx;
	logic [COORD_W-1:0]    off_l, off_t, off_r, off_b;

	// memory stage
	logic                  valid_s2;
	logic [COORD_W-1:0]    left_s2, top_s2, right_s2, bottom_s2;
	logic [POS_W-1:0]      sc_s2, sr_s2;
	logic                  drawn_s2, last_s2, oob_s2;
	logic [PIX_W-1:0]      ram_rdata, pix;

	// output register
	logic                  out_valid_q;
	logic                  out_free, move;

	assign side_w = clamp_side(sprite_width_q);
	assign side_h = clamp_side(sprite_height_q);

	// Hold new requests while a step is still short of the output register.
	assign pixel_req.ready = !step_s1.valid && !valid_s2;
	assign req_accept      = pixel_req.valid && pixel_req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_width_q  <= CFG_SIDE_W'(MAX_SIDE);
			sprite_height_q <= CFG_SIDE_W'(MAX_SIDE);
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			scale_q         <= SCALE_ONE;
			inv_scale_q     <= SCALE_ONE;
			tint_q          <= {TINT_ONE, TINT_ONE, TINT_ONE};
		end else if (write_en) begin
			unique case (reg_t'(reg_index))
				REG_SPRITE_WIDTH:  sprite_width_q  <= write_data[CFG_SIDE_W-1:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= write_data[CFG_SIDE_W-1:0];
				REG_DEST_X:        dest_x_q        <= write_data[COORD_W-1:0];
				REG_DEST_Y:        dest_y_q        <= write_data[COORD_W-1:0];
				REG_SCALE:         scale_q         <= write_data[SCALE_W-1:0];
				REG_INV_SCALE:     inv_scale_q     <= write_data[SCALE_W-1:0];
				REG_TINT:          tint_q          <= write_data;
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// Walk sequencer issues one position per step request while a walk is active.
	stb_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (req_accept),
		.cmd       (pixel_req.cmd),
		.visible   (pixel_req.visible),
		.side_w    (side_w),
		.side_h    (side_h),
		.scale     (scale_q),
		.inv_scale (inv_scale_q),
		.step_s1   (step_s1)
	);

	// Loads write straight into the sprite memory; drop addresses past its end.
	assign store_we = req_accept && (pixel_req.cmd == CMD_LOAD) &&
		(32'(pixel_req.load_addr) < STORE_DEPTH);

	// Source sample: downscale maps through the reciprocal, other modes sample in place.
	always_comb begin
		unique case (step_s1.mode)
			MODE_DOWN: begin
				col_raw = step_s1.col_inv[POS_PROD_W-1:SCALE_FRAC_BITS];
				row_raw = step_s1.row_inv[POS_PROD_W-1:SCALE_FRAC_BITS];
			end
			default: begin
				col_raw = SAMP_W'(step_s1.col);
				row_raw = SAMP_W'(step_s1.row);
			end
		endcase
	end

	// Clamp to the last column or row when the reciprocal overshoots.
	assign col_lim = side_w - 1'b1;
	assign row_lim = side_h - 1'b1;
	assign sc = (col_raw > SAMP_W'(col_lim)) ? POS_W'(col_lim) : POS_W'(col_raw);
	assign sr = (row_raw > SAMP_W'(row_lim)) ? POS_W'(row_lim) : POS_W'(row_raw);
	assign idx = IDX_W'(sr) * IDX_W'(side_w) + IDX_W'(sc);

	// Rectangle offsets: upscale spans floor(pos*scale) to floor((pos+1)*scale).
	always_comb begin
		unique case (step_s1.mode)
			MODE_UP: begin
				off_l = COORD_W'(step_s1.col_scl >> SCALE_FRAC_BITS);
				off_t = COORD_W'(step_s1.row_scl >> SCALE_FRAC_BITS);
				off_r = COORD_W'(step_s1.col_scl_next >> SCALE_FRAC_BITS);
				off_b = COORD_W'(step_s1.row_scl_next >> SCALE_FRAC_BITS);
			end
			default: begin
				off_l = COORD_W'(step_s1.col);
				off_t = COORD_W'(step_s1.row);
				off_r = COORD_W'(step_s1.col);
				off_b = COORD_W'(step_s1.row);
			end
		endcase
	end

	stb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (ADDR_W'(pixel_req.load_addr)),
		.wdata ({pixel_req.red_in, pixel_req.green_in, pixel_req.blue_in}),
		.re    (step_s1.valid),
		.raddr (ADDR_W'(idx)),
		.rdata (ram_rdata)
	);

	// Advance the step into the output register once it is free or being drained.
	assign out_free = !out_valid_q || rect_out.ready;
	assign move     = valid_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_s1.valid) begin
			valid_s2 <= 1'b1;
		end else if (move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1.valid) begin
			left_s2   <= dest_x_q + off_l;
			top_s2    <= dest_y_q + off_t;
			right_s2  <= dest_x_q + off_r;
			bottom_s2 <= dest_y_q + off_b;
			sc_s2     <= sc;
			sr_s2     <= sr;
			drawn_s2  <= step_s1.drawn;
			last_s2   <= step_s1.last;
			oob_s2    <= (32'(idx) >= STORE_DEPTH);
		end
	end

	// Reads past the end of the store give black.
	assign pix = oob_s2 ? '0 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (rect_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rect_out.left      <= left_s2;
			rect_out.top       <= top_s2;
			rect_out.right     <= right_s2;
			rect_out.bottom    <= bottom_s2;
			rect_out.red_out   <= tint_chan(pix[PIX_W-1:2*CHAN_W], tint_q[CFG_W-1:2*TINT_W]);
			rect_out.green_out <= tint_chan(pix[2*CHAN_W-1:CHAN_W],
				tint_q[2*TINT_W-1:TINT_W]);
			rect_out.blue_out  <= tint_chan(pix[CHAN_W-1:0], tint_q[TINT_W-1:0]);
			rect_out.src_col   <= SRC_W'(sc_s2);
			rect_out.src_row   <= SRC_W'(sr_s2);
			rect_out.drawn     <= drawn_s2;
			rect_out.last      <= last_s2;
		end
	end

	assign rect_out.valid = out_valid_q;

`ifndef SYNTHESIS
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_s1.valid && valid_s2))
		else $error("two steps in flight between walk and memory stages");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1.valid |=> valid_s2)
		else $error("position stage did not advance into memory stage");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(left_s2) && $stable(ram_rdata))
		else $error("stalled step lost its payload or read data");

	a_src_in_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		rect_out.valid |-> (SIDE_W'(rect_out.src_col) < side_w) &&
			(SIDE_W'(rect_out.src_row) < side_h))
		else $error("sampled source lies outside the sprite");
`endif

endmodule

`default_nettype wire
